// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define HCS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hcs assertion failed");

// next-cycle implication
`define HCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hcs assertion failed");

`endif

// ----- hdl/hcs_pkg.sv -----
// ----------------------------------------------------------------------------
// hcs_pkg
// shared constants, codes and control types of the contrast stretch block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hcs_pkg;

   localparam int COUNT_BITS = 21;
   localparam int LEVELS     = 256;
   localparam int LEVEL_BITS = 8;
   localparam int BAR_BITS   = 11;
   localparam int QUOT_BITS  = 11;
   localparam int NUM_BITS   = BAR_BITS + COUNT_BITS;
   localparam int STEP_BITS  = $clog2(QUOT_BITS + 1);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = {LEVEL_BITS{1'b1}};
   localparam logic [BAR_BITS-1:0]   BAR_MAX   = 11'd1024;
   localparam logic [BAR_BITS-1:0]   BAR_RESET = 11'd256;

   localparam logic [1:0] FUNC_ACCUM   = 2'd0;
   localparam logic [1:0] FUNC_STRETCH = 2'd1;
   localparam logic [1:0] FUNC_COLUMN  = 2'd2;

   typedef struct packed {
      logic accept;
      logic update;
      logic prep;
      logic div_step;
      logic out_load;
   } hcs_cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       div_done;
   } hcs_status_type;

endpackage

// ----- hdl/histogram_contrast_stretch.sv -----
// ----------------------------------------------------------------------------
// histogram_contrast_stretch
// 256-bin grey-level histogram with linear contrast stretch and bar heights
//
// One request at a time. An accumulate request updates the histogram after
// acceptance and gives no response. A stretch or column request runs the
// 11-step shift-subtract divider, one quotient bit per cycle, before its
// response is loaded; the next request can be accepted in the cycle after the
// response is loaded. A response that is not taken holds the block before it
// loads the following one. The bin counts live in a single-port memory with a
// flip-flop valid bit per bin, so reset and start_frame clear the histogram
// at once, with no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module histogram_contrast_stretch
   import hcs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // pixel[7:0]
   input  logic [2:0]  req_tuser,   // func[1:0], start_frame[2]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // stretched_pixel[7:0], column_height[18:8], zero
   output logic [0:0]  rsp_tuser,   // no_range[0]
   input  logic        csr_we,
   input  logic [10:0] csr_wdata    // bar_height
);

   hcs_cmd_type           cmd;
   hcs_status_type        status;
   logic [LEVEL_BITS-1:0] stretched_pixel;
   logic [BAR_BITS-1:0]   column_height;
   logic                  no_range;

   hcs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   hcs_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_func        (req_tuser[1:0]),
      .req_pixel       (req_tdata),
      .req_start       (req_tuser[2]),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .stretched_pixel (stretched_pixel),
      .column_height   (column_height),
      .no_range        (no_range)
   );

   assign rsp_tdata = {5'b0, column_height, stretched_pixel};
   assign rsp_tuser = no_range;

   `HCS_ASSERT_NEXT(a_accept_busy, clock, reset, req_tvalid && req_tready, !req_tready)
   `HCS_ASSERT_IMPL(a_height_cap, clock, reset, rsp_tvalid, rsp_tdata[18:8] <= 11'd1024)
   `HCS_ASSERT_IMPL(a_one_kind, clock, reset, rsp_tvalid,
                    rsp_tdata[7:0] == 8'd0 || rsp_tdata[18:8] == 11'd0)
   `HCS_ASSERT_IMPL(a_stretch_range, clock, reset, rsp_tvalid && rsp_tdata[7:0] != 8'd0,
                    !rsp_tuser[0])

endmodule

// ----- hdl/hcs_divider.sv -----
// ----------------------------------------------------------------------------
// hcs_divider
// restoring shift-subtract divider, one quotient bit per step
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcs_divider
   import hcs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic                  step,
   input  logic [NUM_BITS-1:0]   numerator,
   input  logic [COUNT_BITS-1:0] denominator,
   output logic [QUOT_BITS-1:0]  quotient,
   output logic                  done
);

   logic [NUM_BITS-1:0]  rem_ff, rem_in;
   logic [NUM_BITS-1:0]  dsh_ff, dsh_in;
   logic [QUOT_BITS-1:0] quot_ff, quot_in;
   logic [STEP_BITS-1:0] cnt_ff, cnt_in;
   logic                 fits;

   assign fits = rem_ff >= dsh_ff;

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      if (load) begin
         rem_in  = numerator;
         dsh_in  = NUM_BITS'(denominator) << (QUOT_BITS - 1);
         quot_in = '0;
         cnt_in  = STEP_BITS'(QUOT_BITS);
      end else if (step) begin
         if (fits) begin
            rem_in = rem_ff - dsh_ff;
         end
         dsh_in  = dsh_ff >> 1;
         quot_in = {quot_ff[QUOT_BITS-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
   end

   assign quotient = quot_ff;
   assign done     = cnt_ff == '0;

endmodule

// ----- hdl/hcs_datapath.sv -----
// ----------------------------------------------------------------------------
// hcs_datapath
// histogram memory, level tracking, bar height register and result path
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcs_datapath
   import hcs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  hcs_cmd_type           cmd,
   output hcs_status_type        status,
   input  logic [1:0]            req_func,
   input  logic [LEVEL_BITS-1:0] req_pixel,
   input  logic                  req_start,
   input  logic                  csr_we,
   input  logic [BAR_BITS-1:0]   csr_wdata,
   output logic [LEVEL_BITS-1:0] stretched_pixel,
   output logic [BAR_BITS-1:0]   column_height,
   output logic                  no_range
);

   localparam logic [1:0] MODE_ZERO = 2'd0;
   localparam logic [1:0] MODE_FULL = 2'd1;
   localparam logic [1:0] MODE_DIV  = 2'd2;

   logic [COUNT_BITS-1:0] hist_mem [LEVELS];
   logic [COUNT_BITS-1:0] mem_rd_ff;

   logic [LEVELS-1:0]     valid_ff, valid_in;
   logic [LEVEL_BITS-1:0] lowest_ff, lowest_in;
   logic [LEVEL_BITS-1:0] highest_ff, highest_in;
   logic [COUNT_BITS-1:0] peak_ff, peak_in;
   logic                  seen_ff, seen_in;
   logic [BAR_BITS-1:0]   bar_ff, bar_in;

   logic [1:0]            func_ff;
   logic [LEVEL_BITS-1:0] pixel_ff;
   logic                  start_ff;

   logic [1:0]            mode_ff, mode_in;
   logic                  flag_ff, flag_in;
   logic [BAR_BITS-1:0]   cap_ff, cap_in;

   logic [LEVEL_BITS-1:0] stretched_ff, stretched_in;
   logic [BAR_BITS-1:0]   column_ff, column_in;
   logic                  no_range_ff;

   logic [COUNT_BITS-1:0]   count_old, count_new, count_q, peak_base;
   logic [LEVEL_BITS-1:0]   lowest_base, highest_base, diff;
   logic [2*LEVEL_BITS-1:0] stretch_num;
   logic [NUM_BITS-1:0]     col_product, div_num;
   logic [COUNT_BITS-1:0]   div_den;
   logic [BAR_BITS-1:0]     bar_cap;
   logic [QUOT_BITS-1:0]    quotient;
   logic                    div_done;

   // histogram memory
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         hist_mem[pixel_ff] <= count_new;
      end
      if (cmd.accept) begin
         mem_rd_ff <= hist_mem[req_pixel];
      end
   end

   // accumulate update
   always_comb begin
      count_old    = (start_ff || !valid_ff[pixel_ff]) ? '0 : mem_rd_ff;
      count_new    = (count_old == COUNT_MAX) ? COUNT_MAX : count_old + 1'b1;
      peak_base    = start_ff ? '0 : peak_ff;
      lowest_base  = start_ff ? LEVEL_MAX : lowest_ff;
      highest_base = start_ff ? '0 : highest_ff;

      valid_in   = valid_ff;
      peak_in    = peak_ff;
      lowest_in  = lowest_ff;
      highest_in = highest_ff;
      seen_in    = seen_ff;
      if (cmd.update) begin
         if (start_ff) begin
            valid_in = '0;
         end
         valid_in[pixel_ff] = 1'b1;
         peak_in    = (count_new > peak_base) ? count_new : peak_base;
         lowest_in  = (pixel_ff < lowest_base) ? pixel_ff : lowest_base;
         highest_in = (pixel_ff > highest_base) ? pixel_ff : highest_base;
         seen_in    = 1'b1;
      end

      bar_in = csr_we ? csr_wdata : bar_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         peak_ff    <= '0;
         lowest_ff  <= LEVEL_MAX;
         highest_ff <= '0;
         seen_ff    <= 1'b0;
         bar_ff     <= BAR_RESET;
      end else begin
         valid_ff   <= valid_in;
         peak_ff    <= peak_in;
         lowest_ff  <= lowest_in;
         highest_ff <= highest_in;
         seen_ff    <= seen_in;
         bar_ff     <= bar_in;
      end
   end

   // request latch
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff  <= req_func;
         pixel_ff <= req_pixel;
         start_ff <= req_start;
      end
   end

   // divide setup
   always_comb begin
      count_q     = valid_ff[pixel_ff] ? mem_rd_ff : '0;
      bar_cap     = (bar_ff > BAR_MAX) ? BAR_MAX : bar_ff;
      diff        = pixel_ff - lowest_ff;
      stretch_num = {diff, {LEVEL_BITS{1'b0}}} - (2*LEVEL_BITS)'(diff);
      col_product = NUM_BITS'(bar_cap) * NUM_BITS'(count_q);

      flag_in = !seen_ff || (highest_ff <= lowest_ff);
      cap_in  = bar_cap;
      if (func_ff == FUNC_COLUMN) begin
         div_num = col_product;
         div_den = peak_ff;
         mode_in = (seen_ff && (peak_ff != '0)) ? MODE_DIV : MODE_ZERO;
      end else begin
         div_num = NUM_BITS'(stretch_num);
         div_den = COUNT_BITS'(highest_ff - lowest_ff);
         if (flag_in || (pixel_ff <= lowest_ff)) begin
            mode_in = MODE_ZERO;
         end else if (pixel_ff >= highest_ff) begin
            mode_in = MODE_FULL;
         end else begin
            mode_in = MODE_DIV;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         mode_ff <= mode_in;
         flag_ff <= flag_in;
         cap_ff  <= cap_in;
      end
   end

   hcs_divider u_divider (
      .clock       (clock),
      .reset       (reset),
      .load        (cmd.prep),
      .step        (cmd.div_step),
      .numerator   (div_num),
      .denominator (div_den),
      .quotient    (quotient),
      .done        (div_done)
   );

   // result register
   always_comb begin
      stretched_in = '0;
      column_in    = '0;
      if (func_ff == FUNC_STRETCH) begin
         case (mode_ff)
            MODE_FULL: stretched_in = LEVEL_MAX;
            MODE_DIV:  stretched_in = quotient[LEVEL_BITS-1:0];
            default:   stretched_in = '0;
         endcase
      end else if (mode_ff == MODE_DIV) begin
         column_in = (quotient > cap_ff) ? cap_ff : quotient;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         stretched_ff <= stretched_in;
         column_ff    <= column_in;
         no_range_ff  <= flag_ff;
      end
   end

   assign status.func     = func_ff;
   assign status.div_done = div_done;

   assign stretched_pixel = stretched_ff;
   assign column_height   = column_ff;
   assign no_range        = no_range_ff;

endmodule

// ----- hdl/hcs_ctrl.sv -----
// ----------------------------------------------------------------------------
// hcs_ctrl
// sequencing state machine and result valid flag
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcs_ctrl
   import hcs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output hcs_cmd_type    cmd,
   input  hcs_status_type status
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_EXEC   = 2'd1;
   localparam logic [1:0] S_DIV    = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_tready = state_ff == S_IDLE;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.accept   = req_tvalid && req_tready;
      case (state_ff)
         S_IDLE: begin
            if (cmd.accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (status.func == FUNC_ACCUM) begin
               cmd.update = 1'b1;
               state_in   = S_IDLE;
            end else if (status.func inside {FUNC_STRETCH, FUNC_COLUMN}) begin
               cmd.prep = 1'b1;
               state_in = S_DIV;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DIV: begin
            if (status.div_done) begin
               state_in = S_FINISH;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ----- tb/hcs_checker.sv -----
// ----------------------------------------------------------------------------
// hcs_checker
// Passive checker for the histogram contrast stretch block.
//
// Watches the request, response and register ports. It keeps its own copy of
// the histogram, the tracked levels, the peak count and the bar height.
// Every accepted stretch or column request queues its expected response.
// Every accepted response is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcs_checker
   import hcs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // pixel[7:0]
   input  logic [2:0]  req_tuser,   // func[1:0], start_frame[2]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,   // stretched_pixel[7:0], column_height[18:8], zero
   input  logic [0:0]  rsp_tuser,   // no_range[0]
   input  logic        csr_we,
   input  logic [10:0] csr_wdata,   // bar_height
   output int          mismatch_count,
   output int          pending_count
);

   typedef struct {
      logic [LEVEL_BITS-1:0] level;
      logic [BAR_BITS-1:0]   height;
      logic                  no_range;
   } hcs_result_type;

   hcs_result_type pending_results[$];

   logic [COUNT_BITS-1:0] bin_count [LEVELS];
   logic [LEVEL_BITS-1:0] lowest;
   logic [LEVEL_BITS-1:0] highest;
   logic [COUNT_BITS-1:0] peak;
   logic                  seen;
   logic [BAR_BITS-1:0]   bar_height;

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic clear_histogram();
      for (int i = 0; i < LEVELS; i++) begin
         bin_count[i] = '0;
      end
      lowest  = LEVEL_MAX;
      highest = '0;
      peak    = '0;
      seen    = 1'b0;
   endtask

   task automatic predict_request(input logic [1:0] fn, input logic [7:0] px,
                                  input logic st);
      logic            flat;
      hcs_result_type  res;
      int unsigned     level;
      longint unsigned h;
      longint unsigned t;
      flat         = !seen || (highest <= lowest);
      res.level    = '0;
      res.height   = '0;
      res.no_range = flat;
      case (fn)
         FUNC_ACCUM: begin
            if (st) begin
               clear_histogram();
            end
            if (bin_count[px] != COUNT_MAX) begin
               bin_count[px] = bin_count[px] + 1'b1;
            end
            if (bin_count[px] > peak) begin
               peak = bin_count[px];
            end
            if (px < lowest) begin
               lowest = px;
            end
            if (px > highest) begin
               highest = px;
            end
            seen = 1'b1;
         end
         FUNC_STRETCH: begin
            level = 0;
            if (!flat) begin
               if (px <= lowest) begin
                  level = 0;
               end else if (px >= highest) begin
                  level = 255;
               end else begin
                  level = ((int'(px) - int'(lowest)) * 255) / (int'(highest) - int'(lowest));
               end
               if (level > 255) begin
                  level = 255;
               end
            end
            res.level = level[7:0];
            pending_results.push_back(res);
         end
         FUNC_COLUMN: begin
            h = (bar_height > BAR_MAX) ? BAR_MAX : bar_height;
            t = 0;
            if (seen && peak != 0) begin
               t = h * bin_count[px];
               t = t / peak;
               if (t > h) begin
                  t = h;
               end
            end
            res.height = t[10:0];
            pending_results.push_back(res);
         end
         default: begin
            // unused code, no response
         end
      endcase
   endtask

   always @(posedge clock) begin : watch
      hcs_result_type want;
      if (reset) begin
         clear_histogram();
         bar_height = BAR_RESET;
         pending_results.delete();
      end else begin
         if (csr_we) begin
            bar_height = csr_wdata;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("response with no request waiting", rsp_tdata, 0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_tdata[7:0] !== want.level) begin
                  report_mismatch("stretched_pixel", rsp_tdata[7:0], want.level);
               end
               if (rsp_tdata[18:8] !== want.height) begin
                  report_mismatch("column_height", rsp_tdata[18:8], want.height);
               end
               if (rsp_tuser[0] !== want.no_range) begin
                  report_mismatch("no_range", rsp_tuser[0], want.no_range);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            predict_request(req_tuser[1:0], req_tdata, req_tuser[2]);
         end
      end
      pending_count <= pending_results.size();
   end

endmodule

// ----- tb/histogram_contrast_stretch_tb.sv -----
// ----------------------------------------------------------------------------
// histogram_contrast_stretch_tb
// Top level of the histogram contrast stretch testbench.
//
// Drives a short directed sequence (empty and flat histograms, levels below
// and above the tracked range, ignored codes and flags), then frames of
// random pixels followed by stretch and column requests, under a series of
// bar heights that includes zero, one, full scale and values above it.
// Both sides idle at random. The checker module predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module histogram_contrast_stretch_tb
   import hcs_pkg::*;
();

   localparam logic [1:0] FUNC_UNUSED  = 2'd3;
   localparam int         PHASES       = 8;
   localparam int         PHASE_ITEMS  = 210;
   localparam int         DRAIN_CYCLES = 30;
   localparam int         STALL_LIMIT  = 3000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // pixel[7:0]
   logic [2:0]  req_tuser  = '0;   // func[1:0], start_frame[2]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // stretched_pixel[7:0], column_height[18:8], zero
   logic [0:0]  rsp_tuser;         // no_range[0]
   logic        csr_we     = 1'b0;
   logic [10:0] csr_wdata  = '0;   // bar_height

   int mismatch_count;
   int pending_count;
   int idle_cycles   = 0;
   int counted_items = 0;
   bit req_gaps_on   = 1'b0;
   bit rsp_stalls_on = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   histogram_contrast_stretch i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   hcs_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // mostly short, now and then long
   function automatic int idle_length();
      if ($urandom_range(0, 9) == 0) begin
         return $urandom_range(10, 60);
      end
      return $urandom_range(1, 3);
   endfunction

   task automatic send_request(input logic [1:0] fn, input logic [7:0] px, input logic st);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      req_tuser  <= {st, fn};
      do @(posedge clock); while (!req_tready);
      if (fn != FUNC_UNUSED) begin
         counted_items++;
      end
      gap = (req_gaps_on && $urandom_range(0, 2) == 0) ? idle_length() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // sender holds off until every response is back and the block has settled
   task automatic wait_for_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // one frame of pixels, mostly within a random range, then queries on it
   task automatic run_frame();
      int          lo;
      int          hi;
      int          pixels;
      int          queries;
      logic [7:0]  px;
      logic [7:0]  last_px;
      logic [1:0]  fn;
      lo = $urandom_range(0, 255);
      hi = ($urandom_range(0, 5) == 0) ? lo : $urandom_range(lo, 255);
      pixels  = $urandom_range(1, 24);
      last_px = 8'(lo);
      for (int i = 0; i < pixels; i++) begin
         case ($urandom_range(0, 9))
            0:       px = 8'($urandom_range(0, 255));
            1, 2:    px = last_px;
            default: px = 8'($urandom_range(lo, hi));
         endcase
         last_px = px;
         send_request(FUNC_ACCUM, px, (i == 0) && ($urandom_range(0, 4) != 0));
         if ($urandom_range(0, 19) == 0) begin
            send_request(FUNC_UNUSED, 8'($urandom), 1'($urandom));
         end
      end
      queries = $urandom_range(2, 12);
      for (int i = 0; i < queries; i++) begin
         fn = $urandom_range(0, 1) ? FUNC_STRETCH : FUNC_COLUMN;
         case ($urandom_range(0, 5))
            0:       px = 8'($urandom_range(0, 255));
            1:       px = 8'(($urandom_range(0, 1) != 0) ? lo : hi);
            2:       px = last_px;
            default: px = 8'($urandom_range(lo, hi));
         endcase
         send_request(fn, px, ($urandom_range(0, 7) == 0));
      end
   endtask

   initial begin : stimulus
      logic [10:0] bar_settings [PHASES];
      bar_settings[0] = 11'd0;
      bar_settings[1] = 11'd1;
      bar_settings[2] = BAR_MAX;
      bar_settings[3] = 11'd1025;
      bar_settings[4] = 11'd2047;
      bar_settings[5] = 11'($urandom_range(2, 1023));
      bar_settings[6] = 11'($urandom_range(1026, 2046));
      bar_settings[7] = BAR_RESET;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty histogram
      send_request(FUNC_STRETCH, 8'd100, 1'b0);
      send_request(FUNC_COLUMN, 8'd5, 1'b0);
      send_request(FUNC_UNUSED, 8'd0, 1'b0);
      // flat histogram
      send_request(FUNC_ACCUM, 8'd77, 1'b1);
      send_request(FUNC_STRETCH, 8'd77, 1'b0);
      send_request(FUNC_COLUMN, 8'd77, 1'b0);
      // full range
      send_request(FUNC_ACCUM, 8'd0, 1'b0);
      send_request(FUNC_ACCUM, 8'd255, 1'b0);
      send_request(FUNC_ACCUM, 8'd128, 1'b0);
      send_request(FUNC_ACCUM, 8'd128, 1'b0);
      send_request(FUNC_STRETCH, 8'd0, 1'b0);
      send_request(FUNC_STRETCH, 8'd255, 1'b0);
      send_request(FUNC_STRETCH, 8'd1, 1'b0);
      send_request(FUNC_STRETCH, 8'd254, 1'b0);
      send_request(FUNC_COLUMN, 8'd128, 1'b0);
      send_request(FUNC_COLUMN, 8'd5, 1'b0);
      // new frame, levels outside the range clamp
      send_request(FUNC_ACCUM, 8'd50, 1'b1);
      send_request(FUNC_ACCUM, 8'd200, 1'b0);
      send_request(FUNC_STRETCH, 8'd10, 1'b0);
      send_request(FUNC_STRETCH, 8'd230, 1'b0);
      send_request(FUNC_STRETCH, 8'd125, 1'b1);
      // start flag ignored off accumulate, unused code ignored
      send_request(FUNC_COLUMN, 8'd50, 1'b1);
      send_request(FUNC_UNUSED, 8'd255, 1'b1);
      send_request(FUNC_COLUMN, 8'd200, 1'b0);

      for (int ph = 0; ph < PHASES; ph++) begin
         wait_for_idle();
         csr_we    <= 1'b1;
         csr_wdata <= bar_settings[ph];
         @(posedge clock);
         csr_we        <= 1'b0;
         req_gaps_on   = (ph != 0) && ($urandom_range(0, 3) != 0);
         rsp_stalls_on = (ph != 0) && ($urandom_range(0, 3) != 0);
         counted_items = 0;
         while (counted_items < PHASE_ITEMS) begin
            run_frame();
         end
      end

      wait_for_idle();
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin : response_side
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else if (rsp_stalls_on && $urandom_range(0, 3) == 0) begin
            hold = idle_length() - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

endmodule
